>>> hw/rtl/srmc_pkg.sv
// Shared types and constants of the steering motor ramp controller.
`default_nettype none

package srmc_pkg;

    localparam int unsigned STICK_W = 8;
    localparam int unsigned POS_W   = 10;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned PER_W   = 16;
    localparam int unsigned DRV_W   = 8;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned PROD_W  = DRV_W + TIME_W;
    localparam int unsigned IN_W    = 56;
    localparam int unsigned OUT_W   = 16;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IDX_W   = 3;

    localparam logic [POS_W-1:0]   RST_STEER_CENTER = 10'd860;
    localparam logic [PER_W-1:0]   RST_RAMP_PERIOD  = 16'd250;
    localparam logic [DRV_W-1:0]   RST_MAX_DRIVE    = 8'd50;
    localparam logic [DRV_W-1:0]   RST_REST_DRIVE   = 8'd20;
    localparam logic [STICK_W-1:0] RST_LEFT_TH      = 8'd108;
    localparam logic [STICK_W-1:0] RST_RIGHT_TH     = 8'd148;
    localparam logic [POS_W-1:0]   RST_MARGIN       = 10'd50;
    localparam logic [DRV_W-1:0]   RST_RAMP_STEP    = 8'd15;
    localparam logic [DRV_W-1:0]   RST_DRIVE_LEVEL  = 8'd20;

    typedef enum logic [IDX_W-1:0] {
        REG_STEER_CENTER,
        REG_RAMP_PERIOD,
        REG_MAX_DRIVE,
        REG_REST_DRIVE,
        REG_LEFT_TH,
        REG_RIGHT_TH,
        REG_MARGIN,
        REG_RAMP_STEP
    } srmc_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } srmc_state_t;

    typedef enum logic [1:0] {
        DRIVE_NONE,
        DRIVE_A,
        DRIVE_B
    } srmc_mode_t;

    typedef struct packed {
        logic [POS_W-1:0]   steer_center;
        logic [PER_W-1:0]   ramp_period;
        logic [DRV_W-1:0]   max_drive;
        logic [DRV_W-1:0]   rest_drive;
        logic [STICK_W-1:0] left_th;
        logic [STICK_W-1:0] right_th;
        logic [POS_W-1:0]   margin;
        logic [DRV_W-1:0]   ramp_step;
    } srmc_cfg_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic mul;
        logic finish;
    } srmc_cmd_t;

    typedef struct packed {
        logic need_ramp;
        logic div_last;
        logic out_free;
    } srmc_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/srmc_ctrl.sv
// Sequencer: accept, serial divide and multiply when a side is driven, result write-back.
`default_nettype none

module srmc_ctrl
    import srmc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire srmc_status_t status,
    output srmc_cmd_t         cmd
);

    srmc_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = status.need_ramp ? ST_DIV : ST_FIN;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_fin_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && !status.out_free) |=> state_reg == ST_FIN)
        else $error("result write-back left FIN while output busy");
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && s_tvalid) |=> state_reg != ST_IDLE)
        else $error("transfer accepted but sequencer stayed idle");
    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> status.out_free)
        else $error("result written over a pending output");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/srmc_dp.sv
// Datapath: decision, serial divider, ramp multiply, state and output register.
`default_nettype none

module srmc_dp
    import srmc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire srmc_cfg_t        cfg,
    input  wire logic [IN_W-1:0]  s_tdata,
    input  wire srmc_cmd_t        cmd,
    output srmc_status_t          status,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata
);

    logic [STICK_W-1:0] stick;
    logic [POS_W:0]     pos11, c11, m11;
    logic [TIME_W-1:0]  now;
    logic               left_req, right_req;
    srmc_mode_t         mode_in;
    logic               ramp_in;

    srmc_mode_t         mode_reg;
    logic               ramp_reg, center_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [PER_W-1:0]   rem_reg;
    logic [TIME_W-1:0]  quo_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [DRV_W-1:0]   drive_reg, drive_next;
    logic [TIME_W-1:0]  last_time_reg;
    logic               m_tvalid_reg;
    logic [OUT_W-1:0]   m_tdata_reg, m_tdata_next;

    logic [PER_W:0]     trial_rem;
    logic [PER_W:0]     trial_diff;
    logic               trial_ok;
    logic [PROD_W-1:0]  sel_lvl;
    logic [DRV_W-1:0]   ramp_lvl;

    assign stick = s_tdata[STICK_W-1:0];
    assign pos11 = {1'b0, s_tdata[STICK_W +: POS_W]};
    assign now   = s_tdata[STICK_W+POS_W +: TIME_W];
    assign c11   = {1'b0, cfg.steer_center};
    assign m11   = {1'b0, cfg.margin};

    assign left_req  = (stick < cfg.left_th) && (stick != '0);
    assign right_req = stick > cfg.right_th;

    always_comb begin
        mode_in = DRIVE_NONE;
        if (left_req) begin
            if (pos11 < c11 + m11) mode_in = DRIVE_B;
        end else if (right_req) begin
            if (pos11 + m11 > c11) mode_in = DRIVE_A;
        end else begin
            if (pos11 > c11 + 11'd1)      mode_in = DRIVE_A;
            else if (pos11 + 11'd1 < c11) mode_in = DRIVE_B;
        end
    end

    assign ramp_in = mode_in != DRIVE_NONE;

    // restoring divide, one quotient bit per cycle; zero divisor yields all ones
    assign trial_rem  = {rem_reg, quo_reg[TIME_W-1]};
    assign trial_diff = trial_rem - {1'b0, cfg.ramp_period};
    assign trial_ok   = trial_rem >= {1'b0, cfg.ramp_period};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg   <= mode_in;
            ramp_reg   <= ramp_in;
            center_reg <= !left_req && !right_req;
            now_reg    <= now;
            rem_reg    <= '0;
            quo_reg    <= now - last_time_reg;
            cnt_reg    <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= trial_ok ? trial_diff[PER_W-1:0] : trial_rem[PER_W-1:0];
            quo_reg <= {quo_reg[TIME_W-2:0], trial_ok};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(cfg.ramp_step) * PROD_W'(quo_reg);
        end
    end

    always_comb begin
        sel_lvl  = (prod_reg > PROD_W'(drive_reg)) ? prod_reg : PROD_W'(drive_reg);
        ramp_lvl = (sel_lvl > PROD_W'(cfg.max_drive)) ? cfg.max_drive : sel_lvl[DRV_W-1:0];
        if (ramp_reg)        drive_next = ramp_lvl;
        else if (center_reg) drive_next = cfg.rest_drive;
        else                 drive_next = drive_reg;
        case (mode_reg)
            DRIVE_A: m_tdata_next = {{DRV_W{1'b0}}, ramp_lvl};
            DRIVE_B: m_tdata_next = {ramp_lvl, {DRV_W{1'b0}}};
            default: m_tdata_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_reg     <= RST_DRIVE_LEVEL;
            last_time_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cmd.finish) begin
                drive_reg <= drive_next;
                if (center_reg) last_time_reg <= now_reg;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) m_tdata_reg <= m_tdata_next;
    end

    assign status.need_ramp = ramp_in;
    assign status.div_last  = cnt_reg == CNT_W'(TIME_W - 1);
    assign status.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("pending result changed");
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[DRV_W-1:0] == '0 || m_tdata[OUT_W-1:DRV_W] == '0))
        else $error("both bridge sides driven");
    a_no_ramp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.finish && mode_reg == DRIVE_NONE) |=> m_tdata == '0)
        else $error("drive output without a ramp");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/steering_motor_ramp_controller.sv
// Top level: configuration registers, sequencer and datapath.
// Sequence when a side is driven: accept, 32-step serial divide of the ramp
// quotient, multiply, write-back; otherwise accept and write-back only.
// A new input is accepted only after the previous result has been written back,
// and write-back waits until the output register is free.
// Reset: synchronous active-low aresetn restores the configuration registers to
// their defaults, the drive level to 20 and the center timestamp to 0.
`default_nettype none

module steering_motor_ramp_controller
    import srmc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_W-1:0]   s_tdata,   // stick_pos[7:0], steer_pos[17:8], time_ms[49:18]
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata    // pwm_a[7:0], pwm_b[15:8]
);

    srmc_cfg_t    cfg_reg;
    srmc_cmd_t    cmd;
    srmc_status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.steer_center <= RST_STEER_CENTER;
            cfg_reg.ramp_period  <= RST_RAMP_PERIOD;
            cfg_reg.max_drive    <= RST_MAX_DRIVE;
            cfg_reg.rest_drive   <= RST_REST_DRIVE;
            cfg_reg.left_th      <= RST_LEFT_TH;
            cfg_reg.right_th     <= RST_RIGHT_TH;
            cfg_reg.margin       <= RST_MARGIN;
            cfg_reg.ramp_step    <= RST_RAMP_STEP;
        end else if (cfg_we) begin
            unique case (srmc_reg_t'(cfg_index))
                REG_STEER_CENTER: cfg_reg.steer_center <= cfg_wdata[POS_W-1:0];
                REG_RAMP_PERIOD:  cfg_reg.ramp_period  <= cfg_wdata[PER_W-1:0];
                REG_MAX_DRIVE:    cfg_reg.max_drive    <= cfg_wdata[DRV_W-1:0];
                REG_REST_DRIVE:   cfg_reg.rest_drive   <= cfg_wdata[DRV_W-1:0];
                REG_LEFT_TH:      cfg_reg.left_th      <= cfg_wdata[STICK_W-1:0];
                REG_RIGHT_TH:     cfg_reg.right_th     <= cfg_wdata[STICK_W-1:0];
                REG_MARGIN:       cfg_reg.margin       <= cfg_wdata[POS_W-1:0];
                REG_RAMP_STEP:    cfg_reg.ramp_step    <= cfg_wdata[DRV_W-1:0];
                default: ;
            endcase
        end
    end

    srmc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    srmc_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
